FILE: sv/lla_pkg.sv
// Shared types and constants for the lane lock allocator.
// Used by lla_regs, lla_div and lane_lock_allocator_affinity; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lla_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_NUM_LANES   = 1024;
    localparam int DEF_NUM_CLIENTS = 16;

    // Field widths
    localparam int ID_W       = 4;
    localparam int LANE_IDX_W = 10;
    localparam int ACT_W      = 11;
    localparam int JUMP_W     = 10;
    localparam int ATT_W      = 8;
    localparam int NEST_W     = 8;

    localparam logic [NEST_W-1:0] NEST_MAX = '1;

    // Configuration reset values
    localparam logic [ACT_W-1:0]  RST_ACTIVE_LANES    = ACT_W'(1024);
    localparam logic [JUMP_W-1:0] RST_START_JUMP      = JUMP_W'(8);
    localparam logic [ATT_W-1:0]  RST_ATTEMPTS_RELOAD = ATT_W'(128);

    // Lock bits are stored in rows of this many lanes
    localparam int LOCK_ROW_W = 32;
    localparam int ROW_OFF_W  = $clog2(LOCK_ROW_W);

    // Shared remainder unit
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // APB port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LANES    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_START_JUMP      = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_ATTEMPTS_RELOAD = REG_IDX_W'(2);

    // Opcodes
    localparam logic OP_HOLD    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BUSY     = 3'd1,
        ST_NO_HOLD  = 3'd2,
        ST_NOT_HELD = 3'd3,
        ST_NEST_OVF = 3'd4
    } t_status;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] client_id;
    } t_in_item;

    typedef struct packed {
        logic [LANE_IDX_W-1:0] lane_index;
        t_status               status;
        logic                  outermost;
    } t_out_item;

    typedef struct packed {
        logic [ACT_W-1:0]  active_lanes;
        logic [JUMP_W-1:0] start_jump;
        logic [ATT_W-1:0]  attempts_reload;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIV_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: sv/lla_regs.sv
// APB configuration registers of the lane lock allocator.
// Depends on lla_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps
`default_nettype none

module lla_regs import lla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_lanes    <= RST_ACTIVE_LANES;
            r_cfg.start_jump      <= RST_START_JUMP;
            r_cfg.attempts_reload <= RST_ATTEMPTS_RELOAD;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ACTIVE_LANES:    r_cfg.active_lanes    <= pwdata[ACT_W-1:0];
                REG_START_JUMP:      r_cfg.start_jump      <= pwdata[JUMP_W-1:0];
                REG_ATTEMPTS_RELOAD: r_cfg.attempts_reload <= pwdata[ATT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACTIVE_LANES:    prdata = APB_DW'(r_cfg.active_lanes);
            REG_START_JUMP:      prdata = APB_DW'(r_cfg.start_jump);
            REG_ATTEMPTS_RELOAD: prdata = APB_DW'(r_cfg.attempts_reload);
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/lla_div.sv
// Shared restoring remainder unit: one quotient bit per cycle.
// Depends on lla_pkg for the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

module lla_div import lla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_dvd;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     r_rem;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] step_rem;

    // dividend is left aligned; steps says how many of its top bits count
    always_comb begin
        trial = {r_rem, r_dvd[DIV_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            diff = trial - {1'b0, r_dvs};
        end else begin
            diff = trial;
        end
        step_rem = diff[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= step_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

endmodule

`default_nettype wire

FILE: sv/lane_lock_allocator_affinity.sv
// Lane lock allocator with client affinity and nesting.
// Inner hold and release skip the lock scan; an outermost hold scans 1 to NUM_LANES/32 + 1
// lock rows of 32 lanes, starting at primary mod active lanes from the shared remainder unit
// and reading one lock row per cycle.
// One transaction at a time; a new one is taken while the last result waits.
// After reset a clearing pass writes every lock row to zero and so frees all locks.
`timescale 1ns / 1ps
`default_nettype none

module lane_lock_allocator_affinity import lla_pkg::*; #(
    parameter int NUM_LANES   = DEF_NUM_LANES,
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int  ROWS      = (NUM_LANES + LOCK_ROW_W - 1) / LOCK_ROW_W;
    localparam int  RIDX_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int  LANE_W    = $clog2(NUM_LANES);
    localparam int  N_W       = $clog2(NUM_LANES + 1);
    localparam int  CL_W      = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam bit  NEED_CMOD = (NUM_CLIENTS < (1 << ID_W));

    typedef struct packed {
        logic [DIV_W-1:0]  primary;
        logic [ATT_W-1:0]  attempts;
        logic [LANE_W-1:0] lane;
        logic [NEST_W-1:0] nest;
    } t_crec;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CMOD, S_DEC, S_PMOD, S_SCHK, S_RLS, S_WB
    } t_state;

    // configuration and shared unit
    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    lla_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer registers
    t_state                 r_state,     n_state;
    logic                   r_op,        n_op;
    logic [CL_W-1:0]        r_c,         n_c;
    t_crec                  r_rec,       n_rec;
    logic [LANE_W-1:0]      r_start,     n_start;
    logic                   r_prim_in,   n_prim_in;
    logic [RIDX_W-1:0]      r_row,       n_row;
    logic                   r_phase,     n_phase;
    t_out_item              r_res,       n_res;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out,       n_out;
    logic [NUM_CLIENTS-1:0] r_assigned,  n_assigned;
    logic [DIV_W-1:0]       r_next_start, n_next_start;

    // lock rows and client records
    logic [LOCK_ROW_W-1:0] r_lmem [ROWS];
    logic [LOCK_ROW_W-1:0] r_lq;
    logic                  lm_we, lm_re;
    logic [RIDX_W-1:0]     lm_waddr, lm_raddr;
    logic [LOCK_ROW_W-1:0] lm_wdata;

    t_crec           r_cmem [NUM_CLIENTS];
    t_crec           r_cq;
    logic            cm_we, cm_re;
    logic [CL_W-1:0] cm_addr;

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            r_lmem[lm_waddr] <= lm_wdata;
        end
        if (lm_re) begin
            r_lq <= r_lmem[lm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            r_cmem[cm_addr] <= r_rec;
        end
        if (cm_re) begin
            r_cq <= r_cmem[cm_addr];
        end
    end

    // usable lane count and its last lane
    logic [DIV_W-1:0]     act32, n32, last32;
    logic [N_W-1:0]       lanes_n;
    logic [RIDX_W-1:0]    last_row;
    logic [ROW_OFF_W-1:0] last_off;

    always_comb begin
        act32 = DIV_W'(cfg.active_lanes);
        if (act32 == '0) begin
            n32 = DIV_W'(1);
        end else if (act32 > DIV_W'(NUM_LANES)) begin
            n32 = DIV_W'(NUM_LANES);
        end else begin
            n32 = act32;
        end
        lanes_n  = N_W'(n32);
        last32   = DIV_W'(lanes_n) - DIV_W'(1);
        last_row = RIDX_W'(last32 >> ROW_OFF_W);
        last_off = last32[ROW_OFF_W-1:0];
    end

    // positions of the scan start and the held lane
    logic [DIV_W-1:0]     start32, lane32;
    logic [RIDX_W-1:0]    start_row, lane_row;
    logic [ROW_OFF_W-1:0] start_off, lane_off;

    always_comb begin
        start32   = DIV_W'(r_start);
        start_row = RIDX_W'(start32 >> ROW_OFF_W);
        start_off = start32[ROW_OFF_W-1:0];
        lane32    = DIV_W'(r_rec.lane);
        lane_row  = RIDX_W'(lane32 >> ROW_OFF_W);
        lane_off  = lane32[ROW_OFF_W-1:0];
    end

    // one lock row per cycle: candidates, lowest free lane, primary probe
    logic [LOCK_ROW_W-1:0] ge_start, le_last, cand, free_bits, low_bit;
    logic [ROW_OFF_W-1:0]  grant_off;
    logic [DIV_W-1:0]      grant32;
    logic                  first_row, prim_busy;
    logic [ATT_W-1:0]      att_eff;

    always_comb begin
        ge_start = {LOCK_ROW_W{1'b1}} << start_off;
        le_last  = ~(({LOCK_ROW_W{1'b1}} << last_off) << 1);
        cand     = {LOCK_ROW_W{1'b1}};
        if (r_row == start_row) begin
            cand = cand & (r_phase ? ~ge_start : ge_start);
        end
        if (r_row == last_row) begin
            cand = cand & le_last;
        end
        free_bits = ~r_lq & cand;
        low_bit   = free_bits & (~free_bits + LOCK_ROW_W'(1));
        grant_off = '0;
        for (int j = 0; j < LOCK_ROW_W; j++) begin
            if (low_bit[j]) begin
                grant_off = grant_off | ROW_OFF_W'(j);
            end
        end
        grant32   = (DIV_W'(r_row) << ROW_OFF_W) | DIV_W'(grant_off);
        // the primary is probed first, and only when it lies below the lane count
        first_row = !r_phase && (r_row == start_row);
        prim_busy = first_row && r_prim_in && r_lq[start_off];
        if (prim_busy && (r_rec.attempts != '0)) begin
            att_eff = r_rec.attempts - ATT_W'(1);
        end else begin
            att_eff = r_rec.attempts;
        end
    end

    // record as read; an unassigned client reads as all zero
    t_crec dec_rec;
    logic  dec_assigned;

    always_comb begin
        dec_assigned = r_assigned[r_c];
        dec_rec      = r_cq;
        if (!dec_assigned) begin
            dec_rec = '0;
        end
    end

    always_comb begin
        t_crec           rec;
        logic [CL_W-1:0] cid;
        rec          = r_rec;
        cid          = r_c;
        n_state      = r_state;
        n_op         = r_op;
        n_c          = r_c;
        n_rec        = r_rec;
        n_start      = r_start;
        n_prim_in    = r_prim_in;
        n_row        = r_row;
        n_phase      = r_phase;
        n_res        = r_res;
        n_out        = r_out;
        n_assigned   = r_assigned;
        n_next_start = r_next_start;
        n_out_valid  = r_out_valid && !i_out_ready;
        lm_we        = 1'b0;
        lm_re        = 1'b0;
        lm_waddr     = r_row;
        lm_raddr     = r_row;
        lm_wdata     = '0;
        cm_we        = 1'b0;
        cm_re        = 1'b0;
        cm_addr      = r_c;
        div_req      = '0;

        case (r_state)
            S_CLEAR: begin
                lm_we = 1'b1;
                if (r_row == RIDX_W'(ROWS - 1)) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row = r_row + RIDX_W'(1);
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_in_data.opcode;
                    if (NEED_CMOD) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {i_in_data.client_id, {(DIV_W - ID_W){1'b0}}};
                        div_req.divisor  = DIV_W'(NUM_CLIENTS);
                        div_req.steps    = DIV_CNT_W'(ID_W);
                        n_state          = S_CMOD;
                    end else begin
                        cid     = CL_W'(DIV_W'(i_in_data.client_id));
                        n_c     = cid;
                        cm_re   = 1'b1;
                        cm_addr = cid;
                        n_state = S_DEC;
                    end
                end
            end

            S_CMOD: begin
                if (div_rsp.done) begin
                    cid     = CL_W'(div_rsp.rem);
                    n_c     = cid;
                    cm_re   = 1'b1;
                    cm_addr = cid;
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                rec = dec_rec;
                if (r_op == OP_HOLD) begin
                    if (!dec_assigned) begin
                        rec.primary       = r_next_start;
                        rec.lane          = '0;
                        rec.attempts      = cfg.attempts_reload;
                        n_assigned[r_c]   = 1'b1;
                        n_next_start      = r_next_start + DIV_W'(cfg.start_jump);
                    end
                    if (rec.nest == '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = rec.primary;
                        div_req.divisor  = DIV_W'(lanes_n);
                        div_req.steps    = DIV_CNT_W'(DIV_W);
                        n_state          = S_PMOD;
                    end else if (rec.nest == NEST_MAX) begin
                        n_res   = '{LANE_IDX_W'(DIV_W'(rec.lane)), ST_NEST_OVF, 1'b0};
                        n_state = S_WB;
                    end else begin
                        rec.nest = rec.nest + NEST_W'(1);
                        n_res    = '{LANE_IDX_W'(DIV_W'(rec.lane)), ST_OK, 1'b0};
                        n_state  = S_WB;
                    end
                end else begin
                    if (rec.nest == '0) begin
                        n_res   = '{LANE_IDX_W'(DIV_W'(rec.lane)), ST_NO_HOLD, 1'b0};
                        n_state = S_WB;
                    end else begin
                        rec.nest = rec.nest - NEST_W'(1);
                        if (rec.nest == '0) begin
                            lm_re    = 1'b1;
                            lm_raddr = RIDX_W'(DIV_W'(rec.lane) >> ROW_OFF_W);
                            n_state  = S_RLS;
                        end else begin
                            n_res   = '{LANE_IDX_W'(DIV_W'(rec.lane)), ST_OK, 1'b0};
                            n_state = S_WB;
                        end
                    end
                end
                n_rec = rec;
            end

            S_PMOD: begin
                if (div_rsp.done) begin
                    n_start   = LANE_W'(div_rsp.rem);
                    n_prim_in = r_rec.primary < n32;
                    n_phase   = 1'b0;
                    n_row     = RIDX_W'(div_rsp.rem >> ROW_OFF_W);
                    lm_re     = 1'b1;
                    lm_raddr  = RIDX_W'(div_rsp.rem >> ROW_OFF_W);
                    n_state   = S_SCHK;
                end
            end

            S_SCHK: begin
                rec.attempts = att_eff;
                if (free_bits != '0) begin
                    lm_we    = 1'b1;
                    lm_wdata = r_lq | low_bit;
                    rec.lane = LANE_W'(grant32);
                    if (grant32 == r_rec.primary) begin
                        rec.attempts = cfg.attempts_reload;
                    end else if (att_eff == '0) begin
                        rec.primary  = grant32;
                        rec.attempts = cfg.attempts_reload;
                    end
                    rec.nest = NEST_W'(1);
                    n_res    = '{LANE_IDX_W'(grant32), ST_OK, 1'b1};
                    n_state  = S_WB;
                end else if (r_phase && (r_row == start_row)) begin
                    // every usable lane seen once, all locked
                    n_res   = '{'0, ST_BUSY, 1'b0};
                    n_state = S_WB;
                end else begin
                    lm_re = 1'b1;
                    if (!r_phase && (r_row == last_row)) begin
                        n_phase  = 1'b1;
                        n_row    = '0;
                        lm_raddr = '0;
                    end else begin
                        n_row    = r_row + RIDX_W'(1);
                        lm_raddr = r_row + RIDX_W'(1);
                    end
                end
                n_rec = rec;
            end

            S_RLS: begin
                lm_waddr = lane_row;
                if (!r_lq[lane_off]) begin
                    n_res = '{LANE_IDX_W'(lane32), ST_NOT_HELD, 1'b0};
                end else begin
                    lm_we    = 1'b1;
                    lm_wdata = r_lq & ~({{(LOCK_ROW_W - 1){1'b0}}, 1'b1} << lane_off);
                    n_res    = '{LANE_IDX_W'(lane32), ST_OK, 1'b0};
                end
                n_state = S_WB;
            end

            S_WB: begin
                cm_we = 1'b1;
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_row        <= '0;
            r_out_valid  <= 1'b0;
            r_assigned   <= '0;
            r_next_start <= '0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_c          <= n_c;
            r_rec        <= n_rec;
            r_start      <= n_start;
            r_prim_in    <= n_prim_in;
            r_row        <= n_row;
            r_phase      <= n_phase;
            r_res        <= n_res;
            r_out_valid  <= n_out_valid;
            r_out        <= n_out;
            r_assigned   <= n_assigned;
            r_next_start <= n_next_start;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_ready_drops_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction taken while one is in flight");

    a_lock_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lm_we |-> (r_state == S_CLEAR || r_state == S_SCHK || r_state == S_RLS))
        else $error("lock row written outside clear, scan or release");

    a_start_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHK) |-> (DIV_W'(r_start) < n32))
        else $error("scan start beyond usable lanes");

    a_assigned_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (($past(r_assigned) & ~r_assigned) == '0))
        else $error("client record lost its assignment");

    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_WB))
        else $error("result raised outside write-back");

endmodule

`default_nettype wire

FILE: dv/lla_lock_checker.sv
// Checker for the lane lock allocator: tracks the register settings and per-client lock state,
// predicts each reply and compares it with what the block returns.
// Depends on lla_pkg for the transaction types, widths and register indexes.
`timescale 1ns / 1ps

module lla_lock_checker import lla_pkg::*; #(
    parameter int NUM_LANES   = DEF_NUM_LANES,
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic [APB_DW-1:0] i_prdata,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    t_cfg                  cfg;
    logic                  lane_locked [NUM_LANES];
    logic [31:0]           start_ctr;
    logic                  assigned    [NUM_CLIENTS];
    logic [31:0]           primary     [NUM_CLIENTS];
    logic [ATT_W-1:0]      budget      [NUM_CLIENTS];
    logic [LANE_IDX_W-1:0] held_lane   [NUM_CLIENTS];
    logic [NEST_W-1:0]     nest        [NUM_CLIENTS];

    t_out_item replies_due[$];
    int        errors  = 0;
    int        checked = 0;

    assign o_errors  = errors;
    assign o_checked = checked;

    task automatic clear_lock_state();
        cfg.active_lanes    = RST_ACTIVE_LANES;
        cfg.start_jump      = RST_START_JUMP;
        cfg.attempts_reload = RST_ATTEMPTS_RELOAD;
        start_ctr = '0;
        for (int i = 0; i < NUM_LANES; i++) lane_locked[i] = 1'b0;
        for (int c = 0; c < NUM_CLIENTS; c++) begin
            assigned[c]  = 1'b0;
            primary[c]   = '0;
            budget[c]    = RST_ATTEMPTS_RELOAD;
            held_lane[c] = '0;
            nest[c]      = '0;
        end
    endtask

    function automatic int usable_lanes();
        int n;
        n = int'(cfg.active_lanes);
        if (n == 0) n = 1;
        if (n > NUM_LANES) n = NUM_LANES;
        return n;
    endfunction

    // Scan from primary mod n, wrapping once; busy probes of the primary burn budget.
    function automatic bit claim_lane(int c);
        int n;
        int first;
        int idx;
        n     = usable_lanes();
        first = int'(primary[c] % 32'(n));
        for (int k = 0; k < n; k++) begin
            idx = first + k;
            if (idx >= n) idx -= n;
            if (!lane_locked[idx]) begin
                lane_locked[idx] = 1'b1;
                held_lane[c]     = LANE_IDX_W'(idx);
                if (32'(idx) == primary[c]) begin
                    budget[c] = cfg.attempts_reload;
                end else if (budget[c] == '0) begin
                    primary[c] = 32'(idx);
                    budget[c]  = cfg.attempts_reload;
                end
                return 1'b1;
            end
            if (32'(idx) == primary[c] && budget[c] != '0) budget[c]--;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item predict_lock_reply(t_in_item req);
        int        c;
        t_out_item r;
        c            = int'(req.client_id) % NUM_CLIENTS;
        r.lane_index = '0;
        r.status     = ST_OK;
        r.outermost  = 1'b0;
        if (req.opcode == OP_HOLD) begin
            if (!assigned[c]) begin
                assigned[c]  = 1'b1;
                primary[c]   = start_ctr;
                held_lane[c] = '0;
                budget[c]    = cfg.attempts_reload;
                start_ctr    = start_ctr + 32'(cfg.start_jump);
            end
            if (nest[c] == '0) begin
                if (!claim_lane(c)) begin
                    r.status = ST_BUSY;
                    return r;
                end
                nest[c]      = NEST_W'(1);
                r.lane_index = held_lane[c];
                r.outermost  = 1'b1;
                return r;
            end
            r.lane_index = held_lane[c];
            if (nest[c] == NEST_MAX) begin
                r.status = ST_NEST_OVF;
                return r;
            end
            nest[c]++;
            return r;
        end
        r.lane_index = held_lane[c];
        if (nest[c] == '0) begin
            r.status = ST_NO_HOLD;
            return r;
        end
        nest[c]--;
        if (nest[c] == '0) begin
            if (!lane_locked[held_lane[c]]) begin
                r.status = ST_NOT_HELD;
                return r;
            end
            lane_locked[held_lane[c]] = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item        want;
        logic [APB_DW-1:0] reg_val;
        logic              known_reg;
        if (!i_rst_n) begin
            clear_lock_state();
            replies_due.delete();
        end else begin
            // retire the oldest reply before queuing a new request
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    errors++;
                    $error("reply with nothing outstanding: lane %0d status %0d outermost %0d",
                           i_out_data.lane_index, i_out_data.status, i_out_data.outermost);
                end else begin
                    want = replies_due.pop_front();
                    checked++;
                    if (i_out_data.lane_index !== want.lane_index) begin
                        errors++;
                        $error("lane_index: expected %0d, got %0d",
                               want.lane_index, i_out_data.lane_index);
                    end
                    if (i_out_data.status !== want.status) begin
                        errors++;
                        $error("status: expected %0d, got %0d", want.status, i_out_data.status);
                    end
                    if (i_out_data.outermost !== want.outermost) begin
                        errors++;
                        $error("outermost: expected %0d, got %0d",
                               want.outermost, i_out_data.outermost);
                    end
                end
            end
            if (i_in_valid && i_in_ready) replies_due.push_back(predict_lock_reply(i_in_data));
            if (i_psel && i_penable && i_pready) begin
                known_reg = 1'b1;
                reg_val   = '0;
                case (i_paddr[APB_AW-1:2])
                    REG_ACTIVE_LANES: begin
                        if (i_pwrite) cfg.active_lanes = i_pwdata[ACT_W-1:0];
                        reg_val = APB_DW'(cfg.active_lanes);
                    end
                    REG_START_JUMP: begin
                        if (i_pwrite) cfg.start_jump = i_pwdata[JUMP_W-1:0];
                        reg_val = APB_DW'(cfg.start_jump);
                    end
                    REG_ATTEMPTS_RELOAD: begin
                        if (i_pwrite) cfg.attempts_reload = i_pwdata[ATT_W-1:0];
                        reg_val = APB_DW'(cfg.attempts_reload);
                    end
                    default: known_reg = 1'b0;
                endcase
                if (!i_pwrite && known_reg && i_prdata !== reg_val) begin
                    errors++;
                    $error("prdata: expected %0d, got %0d", reg_val, i_prdata);
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

FILE: dv/tb_lane_lock_allocator_affinity.sv
// Testbench top for lane_lock_allocator_affinity: clock, reset, register setup over APB,
// request stimulus and reply back-pressure; checking is done by lla_lock_checker.
// Depends on lla_pkg, lla_lock_checker and the block itself.
`timescale 1ns / 1ps

module tb_lane_lock_allocator_affinity;
    import lla_pkg::*;

    localparam int IDLE_PCT       = 27;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_AT    = 150;
    localparam int PRESSURE_LEN   = 300;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_REQS     = 22;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int errors;
    int pending;
    int checked;
    int reqs_sent     = 0;
    int settings_done = 0;
    int replies_seen  = 0;
    int stall_cycles  = 0;
    bit sender_steady = 1'b0;

    lane_lock_allocator_affinity uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lla_lock_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Reply side: random stalls, one long hold-off to back the block up, then a stall-free run.
    initial begin
        int hold_cycles;
        bit held_off;
        held_off    = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && replies_seen >= PRESSURE_AT) begin
                held_off    = 1'b1;
                i_out_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < PRESSURE_LEN) begin
                    @(negedge i_clk);
                    hold_cycles++;
                end
            end
            i_out_ready <= (replies_seen >= 200 && replies_seen < 320) ||
                           ($urandom_range(99) >= IDLE_PCT);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) replies_seen++;
        end
    end

    // Watchdog: any transaction or register access restarts the count.
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $error("no transaction for %0d cycles, %0d replies outstanding", stall_cycles, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Write one register, then read it back; called at a falling edge.
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input int active, input int jump, input int reload);
        // stop offering the last request so it is not taken a second time
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        set_reg(REG_ACTIVE_LANES, APB_DW'(active));
        set_reg(REG_START_JUMP, APB_DW'(jump));
        set_reg(REG_ATTEMPTS_RELOAD, APB_DW'(reload));
        settings_done++;
    endtask

    // Offer one request; returns at the falling edge after it is taken.
    task automatic push_req(input logic op, input int client);
        while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_data.opcode    <= op;
        i_in_data.client_id <= ID_W'(client);
        do @(posedge i_clk); while (!o_in_ready);
        reqs_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        int pool_lo;
        int pool_n;
        int client;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // let the lock-clearing pass after reset finish
        repeat (64) @(negedge i_clk);

        // Directed: two usable lanes, so a third client finds none free.
        apply_setting(2, 1023, 2);
        push_req(OP_RELEASE, 15);
        push_req(OP_RELEASE, 0);
        push_req(OP_HOLD, 0);
        push_req(OP_HOLD, 0);
        push_req(OP_HOLD, 15);     // primary far above the usable lanes
        push_req(OP_HOLD, 5);      // busy
        push_req(OP_HOLD, 5);
        push_req(OP_RELEASE, 0);
        push_req(OP_RELEASE, 0);
        push_req(OP_HOLD, 5);
        push_req(OP_HOLD, 0);      // busy again
        push_req(OP_RELEASE, 15);
        push_req(OP_HOLD, 0);
        push_req(OP_RELEASE, 5);
        push_req(OP_RELEASE, 0);
        push_req(OP_RELEASE, 5);

        // Nest one client up to the limit and past it.
        apply_setting(1024, 8, 128);
        for (int i = 0; i < 257; i++) push_req(OP_HOLD, 3);
        push_req(OP_RELEASE, 3);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_setting(1, 0, 0);
                1: apply_setting(2047, 1023, 255);
                2: apply_setting(0, $urandom_range(1023), 1);
                3: apply_setting(3, $urandom_range(1023), $urandom_range(255));
                4: apply_setting($urandom_range(1, 64), $urandom_range(1023), $urandom_range(255));
                5: apply_setting(1024, 8, 128);
                6: apply_setting($urandom_range(2047), $urandom_range(1023), $urandom_range(255));
                default: apply_setting(4, 1, 3);
            endcase
            sender_steady = (p == 1);
            // most traffic from a small group of clients so holds and releases pair up
            pool_lo = $urandom_range(15);
            pool_n  = $urandom_range(2, 5);
            for (int i = 0; i < PHASE_REQS; i++) begin
                if ($urandom_range(99) < 80)
                    client = (pool_lo + $urandom_range(pool_n - 1)) % 16;
                else
                    client = $urandom_range(15);
                push_req(($urandom_range(99) < 55) ? OP_HOLD : OP_RELEASE, client);
            end
        end
        sender_steady = 1'b0;
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Ran %0d lock requests across %0d register settings; %0d replies compared.",
                 reqs_sent, settings_done, checked);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
sv/lla_pkg.sv
sv/lla_regs.sv
sv/lla_div.sv
sv/lane_lock_allocator_affinity.sv
dv/lla_lock_checker.sv
dv/tb_lane_lock_allocator_affinity.sv
